### rtl/mie_pkg.sv
// Shared types, constants and the opcode decoder of the I-type execute unit.
`timescale 1ns / 1ps
package mie_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int ROWS      = MEM_BYTES / 4;
  localparam int ROW_AW    = MEM_AW - 2;

  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_BLEZ  = 6'h06;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_ANDI  = 6'h0C;
  localparam logic [5:0] OPC_ORI   = 6'h0D;
  localparam logic [5:0] OPC_LUI   = 6'h0F;
  localparam logic [5:0] OPC_LB    = 6'h20;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SB    = 6'h28;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  localparam logic [2:0] ACC_NONE = 3'd0;
  localparam logic [2:0] ACC_LW   = 3'd1;
  localparam logic [2:0] ACC_LB   = 3'd2;
  localparam logic [2:0] ACC_SW   = 3'd3;
  localparam logic [2:0] ACC_SB   = 3'd4;

  typedef enum logic [3:0] {
    OP_LUI, OP_ORI, OP_ANDI, OP_ADDIU, OP_BEQ, OP_BNE, OP_BLEZ,
    OP_LW, OP_LB, OP_SW, OP_SB, OP_ILL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] pc;
  } uop_t;

  function automatic op_t decode(input logic [5:0] opc);
    op_t op;
    unique case (opc)
      OPC_LUI:   op = OP_LUI;
      OPC_ORI:   op = OP_ORI;
      OPC_ANDI:  op = OP_ANDI;
      OPC_ADDIU: op = OP_ADDIU;
      OPC_BEQ:   op = OP_BEQ;
      OPC_BNE:   op = OP_BNE;
      OPC_BLEZ:  op = OP_BLEZ;
      OPC_LW:    op = OP_LW;
      OPC_LB:    op = OP_LB;
      OPC_SW:    op = OP_SW;
      OPC_SB:    op = OP_SB;
      default:   op = OP_ILL;
    endcase
    return op;
  endfunction

endpackage

### rtl/mie_front.sv
// Front end: accepts instruction transactions and decodes them into queue entries.
`timescale 1ns / 1ps
module mie_front (
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [63:0]    s_tdata,   // instr_word [31:0], pc [63:32]
  input  logic           clearing,
  input  logic           q_full,
  output logic           push,
  output mie_pkg::uop_t  push_data
);

  assign s_tready = !q_full && !clearing;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_data.op  = mie_pkg::decode(s_tdata[31:26]);
    push_data.rs  = s_tdata[25:21];
    push_data.rt  = s_tdata[20:16];
    push_data.imm = s_tdata[15:0];
    push_data.pc  = s_tdata[63:32];
  end

endmodule

### rtl/mie_queue.sv
// Two-entry queue between the decode front end and the execute back end.
`timescale 1ns / 1ps
module mie_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mie_pkg::uop_t  din,
  output logic           full,
  input  logic           pop,
  output mie_pkg::uop_t  dout,
  output logic           empty
);

  mie_pkg::uop_t entries [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

endmodule

### rtl/mie_back.sv
// Back end: register file, banked data memory and the two-stage execute pipeline.
`timescale 1ns / 1ps
module mie_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mie_pkg::uop_t  q_dout,
  output logic           pop,
  output logic           clearing,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [111:0]   m_tdata
);

  localparam int ROW_AW = mie_pkg::ROW_AW;

  logic              advance;
  logic [ROW_AW-1:0] clr_row;

  // Read stage: entry waiting for its register operands.
  logic              s2_valid;
  mie_pkg::uop_t     s2;
  logic [31:0]       rd_a, rd_b;
  logic              ra_ok, rb_ok;

  // Result stage.
  logic              s3_valid;
  mie_pkg::op_t      s3_op;
  logic              s3_wr;
  logic [4:0]        s3_rt;
  logic [31:0]       s3_alu;
  logic [31:0]       s3_npc;
  logic              s3_taken;
  logic [2:0]        s3_kind;
  logic [31:0]       s3_addr;
  logic [1:0]        s3_lane;
  logic [31:0]       s3_wval;

  // Write that landed in the register file at the edge the read stage sampled it.
  logic              wbh_valid;
  logic [4:0]        wbh_reg;
  logic [31:0]       wbh_val;

  logic [31:0]       rf [32];
  logic [31:0]       rf_valid;

  logic [7:0]        rdata [4];

  assign advance  = !s3_valid || m_tready;
  assign pop      = advance && !q_empty && !clearing;
  assign m_tvalid = s3_valid;

  // Clearing pass over the data memory rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_AW'(mie_pkg::ROWS - 1)) clearing <= 1'b0;
    end
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_a <= rf[q_dout.rs];
      rd_b <= rf[q_dout.rt];
    end
    if (advance && s3_valid && s3_wr) rf[s3_rt] <= s3_wval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      ra_ok    <= 1'b0;
      rb_ok    <= 1'b0;
    end else begin
      if (pop) begin
        ra_ok <= rf_valid[q_dout.rs];
        rb_ok <= rf_valid[q_dout.rt];
      end
      if (advance && s3_valid && s3_wr) rf_valid[s3_rt] <= 1'b1;
    end
  end

  // Operand forwarding: nearest producer first.
  logic [31:0] a, b;
  always_comb begin
    if (s3_valid && s3_wr && s3_rt == s2.rs)       a = s3_wval;
    else if (wbh_valid && wbh_reg == s2.rs)       a = wbh_val;
    else                                          a = ra_ok ? rd_a : 32'd0;
    if (s3_valid && s3_wr && s3_rt == s2.rt)       b = s3_wval;
    else if (wbh_valid && wbh_reg == s2.rt)       b = wbh_val;
    else                                          b = rb_ok ? rd_b : 32'd0;
  end

  logic [31:0] seimm, ea, seq, alu, npc;
  logic        taken, wr, is_load, is_store;
  logic [2:0]  kind;

  always_comb begin
    seimm    = {{16{s2.imm[15]}}, s2.imm};
    ea       = a + seimm;
    seq      = s2.pc + 32'd4;
    alu      = 32'd0;
    taken    = 1'b0;
    wr       = 1'b0;
    kind     = mie_pkg::ACC_NONE;
    unique case (s2.op)
      mie_pkg::OP_LUI:   begin wr = 1'b1; alu = {s2.imm, 16'd0}; end
      mie_pkg::OP_ORI:   begin wr = 1'b1; alu = a | {16'd0, s2.imm}; end
      mie_pkg::OP_ANDI:  begin wr = 1'b1; alu = a & {16'd0, s2.imm}; end
      mie_pkg::OP_ADDIU: begin wr = 1'b1; alu = ea; end
      mie_pkg::OP_BEQ:   taken = (a == b);
      mie_pkg::OP_BNE:   taken = (a != b);
      mie_pkg::OP_BLEZ:  taken = a[31] || (a == 32'd0);
      mie_pkg::OP_LW:    begin wr = 1'b1; kind = mie_pkg::ACC_LW; end
      mie_pkg::OP_LB:    begin wr = 1'b1; kind = mie_pkg::ACC_LB; end
      mie_pkg::OP_SW:    kind = mie_pkg::ACC_SW;
      mie_pkg::OP_SB:    kind = mie_pkg::ACC_SB;
      default: ;
    endcase
    if (s2.rt == 5'd0) wr = 1'b0;
    npc      = seq + (taken ? {seimm[29:0], 2'b00} : 32'd0);
    is_load  = (s2.op == mie_pkg::OP_LW) || (s2.op == mie_pkg::OP_LB);
    is_store = (s2.op == mie_pkg::OP_SW) || (s2.op == mie_pkg::OP_SB);
  end

  // Four byte banks; bank k holds the bytes whose address ends in k.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]        ram [mie_pkg::ROWS];
    logic [ROW_AW-1:0] row;
    logic [1:0]        lane;
    logic [7:0]        wd;
    logic              we;

    always_comb begin
      row  = ea[mie_pkg::MEM_AW-1:2] + ROW_AW'(2'(k) < ea[1:0]);
      lane = 2'(k) - ea[1:0];
      wd   = (s2.op == mie_pkg::OP_SW) ? b[8*lane +: 8] : b[7:0];
      we   = (s2.op == mie_pkg::OP_SW) || ((s2.op == mie_pkg::OP_SB) && ea[1:0] == 2'(k));
    end

    always_ff @(posedge clk) begin
      if (clearing) ram[clr_row] <= 8'd0;
      else if (advance && s2_valid && we) ram[row] <= wd;
      if (advance && s2_valid && is_load) rdata[k] <= ram[row];
    end
  end

  // Load data assembly in the result stage.
  always_comb begin
    if (s3_op == mie_pkg::OP_LW)
      s3_wval = {rdata[s3_lane + 2'd3], rdata[s3_lane + 2'd2],
                 rdata[s3_lane + 2'd1], rdata[s3_lane]};
    else if (s3_op == mie_pkg::OP_LB)
      s3_wval = {{24{rdata[s3_lane][7]}}, rdata[s3_lane]};
    else
      s3_wval = s3_alu;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      wbh_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= pop;
      s3_valid  <= s2_valid;
      wbh_valid <= s3_valid && s3_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pop) s2 <= q_dout;
      wbh_reg  <= s3_rt;
      wbh_val  <= s3_wval;
      s3_op    <= s2.op;
      s3_wr    <= wr;
      s3_rt    <= wr ? s2.rt : 5'd0;
      s3_alu   <= alu;
      s3_npc   <= npc;
      s3_taken <= taken;
      s3_kind  <= kind;
      s3_addr  <= (is_load || is_store) ? ea : 32'd0;
      s3_lane  <= ea[1:0];
    end
  end

  assign m_tdata = {5'd0,
                    (s3_op == mie_pkg::OP_ILL),
                    s3_addr,
                    s3_kind,
                    s3_wr ? s3_wval : 32'd0,
                    s3_rt,
                    s3_wr,
                    s3_taken,
                    s3_npc};

endmodule

### rtl/mips_itype_execute_unit.sv
// Top level of the MIPS32 I-type execute unit.
`timescale 1ns / 1ps
// Executes one I-type instruction per transaction against an internal 32-entry
// register file and a 4096-byte little-endian data memory held in four byte
// banks. After reset the unit clears the data memory row by row and holds
// s_tready low meanwhile. It then takes one instruction per cycle while the
// output is not stalled; each result passes from the queue into the
// register-read stage and then into the result stage, with the memory accessed
// on that second step, and register results are forwarded so dependent
// instructions need no stall. Two queue entries decouple the input from
// output back-pressure.
module mips_itype_execute_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // instr_word [31:0], pc [63:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // next_pc, branch_taken, reg_write, write_reg,
                                  // write_value, access_kind, access_addr, illegal
);

  logic          clearing, q_full, q_empty, push, pop;
  mie_pkg::uop_t push_data, q_dout;

  mie_front u_front (
    .s_tvalid, .s_tready, .s_tdata, .clearing, .q_full, .push, .push_data
  );

  mie_queue u_queue (
    .clk, .rst, .push, .din(push_data), .full(q_full), .pop, .dout(q_dout),
    .empty(q_empty)
  );

  mie_back u_back (
    .clk, .rst, .q_empty, .q_dout, .pop, .clearing, .m_tvalid, .m_tready, .m_tdata
  );

endmodule
